// ===== design/acrp_pkg.sv =====
// Shared types, constants and command codes for the alignment column reorder path.
`timescale 1ns / 1ps

package acrp_pkg;

  localparam int MAX_SEQS     = 16;
  localparam int MAX_COLS_DEF = 1024;

  localparam int PRES_W     = 16;
  localparam int SEQ_W      = 4;
  localparam int SEQ_CNT_W  = 5;
  localparam int CODE_W     = 2;
  localparam int COORD_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Sequences that can take part in the ordering at most.
  localparam int SEQ_LIM = (MAX_SEQS < PRES_W) ? MAX_SEQS : PRES_W;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  localparam int BIT_FIRST  = 0;
  localparam int BIT_SECOND = 1;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_COUNT  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_ISSUE,
    OP_READ_OUT,
    OP_READ_EMPTY,
    OP_SORT_CHK,
    OP_SORT_RA,
    OP_SORT_RB,
    OP_SORT_CMP,
    OP_SORT_WB,
    OP_PROJ
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sort_start;
  } cmd_t;

  typedef struct packed {
    logic can_read;
    logic sort_more;
    logic swap;
    logic proj_done;
  } status_t;

endpackage

// ===== design/alignment_column_reorder_path.sv =====
// Top level of the alignment column reorder path: controller, datapath and ports.
`timescale 1ns / 1ps
// A drain read keeps busy high for one cycle and its word passes the store read register
// and the output register to the out_ strobe; a read with nothing left is answered in
// the next cycle. The sort after the last load is bounded by the single port pair of
// the column store: a compare steps through check, two reads and compare, a swap adds
// a write-back, then projection runs over the columns. The receiver cannot stall.
// rst_n is synchronous: the store is empty, configuration returns to its defaults.

module alignment_column_reorder_path #(
  parameter int MAX_COLS = acrp_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [acrp_pkg::PRES_W-1:0]     in_presence,
  input  logic                            in_last_column,
  output logic                            out_valid,
  output logic [acrp_pkg::CODE_W-1:0]     out_code,
  output logic [acrp_pkg::COORD_W-1:0]    out_x_count,
  output logic [acrp_pkg::COORD_W-1:0]    out_y_count,
  output logic                            out_final_step,
  output logic                            out_empty_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [acrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acrp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import acrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  acrp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_operation   (in_operation),
    .in_last_column (in_last_column),
    .status         (status),
    .cmd            (cmd),
    .busy           (busy)
  );

  acrp_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_presence    (in_presence),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_code       (out_code),
    .out_x_count    (out_x_count),
    .out_y_count    (out_y_count),
    .out_final_step (out_final_step),
    .out_empty_res  (out_empty_res)
  );

endmodule

// ===== design/acrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module acrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/acrp_ctrl.sv =====
// Controller state machine: sequences loads, drain reads, the column sort and the projection.
`timescale 1ns / 1ps

module acrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  input  logic              in_last_column,
  input  acrp_pkg::status_t status,
  output acrp_pkg::cmd_t    cmd,
  output logic              busy
);

  import acrp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHK,
    ST_RA,
    ST_RB,
    ST_CMP,
    ST_WB,
    ST_PROJ
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    cmd.op         = OP_NONE;
    cmd.sort_start = 1'b0;
    state_nxt      = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OPER_LOAD) begin
            cmd.op = OP_LOAD;
            if (in_last_column) begin
              cmd.sort_start = 1'b1;
              state_nxt      = ST_CHK;
            end
          end else if (status.can_read) begin
            cmd.op    = OP_READ_ISSUE;
            state_nxt = ST_READ;
          end else begin
            cmd.op = OP_READ_EMPTY;
          end
        end
      end
      ST_READ: begin
        cmd.op    = OP_READ_OUT;
        state_nxt = ST_IDLE;
      end
      ST_CHK: begin
        cmd.op    = OP_SORT_CHK;
        state_nxt = status.sort_more ? ST_RA : ST_PROJ;
      end
      ST_RA: begin
        cmd.op    = OP_SORT_RA;
        state_nxt = ST_RB;
      end
      ST_RB: begin
        cmd.op    = OP_SORT_RB;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.op    = OP_SORT_CMP;
        state_nxt = status.swap ? ST_WB : ST_CHK;
      end
      ST_WB: begin
        cmd.op    = OP_SORT_WB;
        state_nxt = ST_CHK;
      end
      ST_PROJ: begin
        cmd.op = OP_PROJ;
        if (status.proj_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // The last column load always hands over to the sort.
  a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r && (in_operation == OPER_LOAD) && in_last_column |=> busy_r)
    else $error("last column load did not start the sort");

  // A read with nothing to return is answered at once and leaves the block free.
  a_empty_read_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r && (in_operation == OPER_READ) && !status.can_read |=> !busy_r)
    else $error("empty read made the block busy");

  // The second half of a swap only follows a compare that decided to swap.
  a_wb_after_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> ($past(state_r) == ST_CMP) && $past(status.swap))
    else $error("swap write-back without a swap decision");

endmodule

// ===== design/acrp_dp.sv =====
// Datapath: column store, configuration, sort compare, projection and path counters.
`timescale 1ns / 1ps

module acrp_dp #(
  parameter int MAX_COLS = acrp_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  acrp_pkg::cmd_t                  cmd,
  output acrp_pkg::status_t               status,
  input  logic [acrp_pkg::PRES_W-1:0]     in_presence,
  input  logic                            cfg_valid,
  input  logic [acrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acrp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  output logic [acrp_pkg::CODE_W-1:0]     out_code,
  output logic [acrp_pkg::COORD_W-1:0]    out_x_count,
  output logic [acrp_pkg::COORD_W-1:0]    out_y_count,
  output logic                            out_final_step,
  output logic                            out_empty_res
);

  import acrp_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam logic [CNT_W-1:0] COLS_LIM = CNT_W'(MAX_COLS);

  typedef enum logic {
    PH_LOAD,
    PH_DRAIN
  } phase_t;

  // Configuration
  logic [SEQ_W-1:0]     first_seq_r, second_seq_r;
  logic [SEQ_CNT_W-1:0] seq_count_r;
  logic [SEQ_CNT_W-1:0] n_use;
  logic [PRES_W-1:0]    keep;

  // Control state
  phase_t             phase_r;
  logic [CNT_W-1:0]   total_r, read_index_r, idx_r, out_ptr_r;
  logic [CNT_W-1:0]   total_eff, idx_inc;
  logic               pend_r;
  logic [COORD_W-1:0] x_r, y_r, x_nxt, y_nxt;

  // Payload
  logic [PRES_W-1:0]  a_r;
  logic               out_valid_r, out_final_r, out_empty_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;

  // Memory port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PRES_W-1:0] ram_wdata, ram_rdata;

  // Compare and projection
  logic [PRES_W-1:0] col_q, diff, low_bit;
  logic              later_wins, swap;
  logic [CODE_W-1:0] pcode, rd_code;

  acrp_ram #(
    .WIDTH (PRES_W),
    .DEPTH (MAX_COLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Presence bits of sequences beyond those in use are ignored on every sort and projection read.
  assign n_use = (seq_count_r > SEQ_CNT_W'(SEQ_LIM)) ? SEQ_CNT_W'(SEQ_LIM) : seq_count_r;

  always_comb begin
    for (int i = 0; i < PRES_W; i++) begin
      keep[i] = (SEQ_CNT_W'(i) < n_use);
    end
  end

  assign col_q = ram_rdata & keep;

  // With disjoint columns every differing bit is a present one. The first chosen
  // sequence decides first, then the second, then the lowest remaining index.
  assign diff    = a_r ^ col_q;
  assign low_bit = diff & (~diff + PRES_W'(1));

  always_comb begin
    if (diff[first_seq_r]) begin
      later_wins = col_q[first_seq_r];
    end else if (diff[second_seq_r]) begin
      later_wins = col_q[second_seq_r];
    end else begin
      later_wins = |(low_bit & col_q);
    end
  end

  assign swap    = ((a_r & col_q) == '0) && later_wins;
  assign pcode   = {col_q[second_seq_r], col_q[first_seq_r]};
  assign rd_code = ram_rdata[CODE_W-1:0];

  assign total_eff = (phase_r == PH_DRAIN) ? '0 : total_r;
  assign idx_inc   = idx_r + CNT_W'(1);

  assign x_nxt = (rd_code[BIT_FIRST] && (x_r != COORD_MAX)) ? x_r + COORD_W'(1) : x_r;
  assign y_nxt = (rd_code[BIT_SECOND] && (y_r != COORD_MAX)) ? y_r + COORD_W'(1) : y_r;

  assign status.can_read  = (phase_r == PH_DRAIN) && (read_index_r < total_r);
  assign status.sort_more = (idx_inc < total_r);
  assign status.swap      = swap;
  assign status.proj_done = (idx_r >= total_r) && !pend_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        ram_we    = (total_eff < COLS_LIM);
        ram_waddr = total_eff[ADDR_W-1:0];
        ram_wdata = in_presence;
      end
      OP_READ_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = read_index_r[ADDR_W-1:0];
      end
      OP_SORT_RA: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[ADDR_W-1:0];
      end
      OP_SORT_RB: begin
        ram_re    = 1'b1;
        ram_raddr = idx_inc[ADDR_W-1:0];
      end
      OP_SORT_CMP: begin
        ram_we    = swap;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = col_q;
      end
      OP_SORT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_inc[ADDR_W-1:0];
        ram_wdata = a_r;
      end
      OP_PROJ: begin
        // The write pointer never passes the read pointer, so compaction is in place.
        ram_re    = (idx_r < total_r);
        ram_raddr = idx_r[ADDR_W-1:0];
        ram_we    = pend_r && (pcode != '0);
        ram_waddr = out_ptr_r[ADDR_W-1:0];
        ram_wdata = {{(PRES_W-CODE_W){1'b0}}, pcode};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seq_r  <= SEQ_W'(0);
      second_seq_r <= SEQ_W'(1);
      seq_count_r  <= SEQ_CNT_W'(16);
      phase_r      <= PH_LOAD;
      total_r      <= '0;
      read_index_r <= '0;
      idx_r        <= '0;
      out_ptr_r    <= '0;
      pend_r       <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FIRST_SEQ:  first_seq_r  <= cfg_data[SEQ_W-1:0];
          REG_SECOND_SEQ: second_seq_r <= cfg_data[SEQ_W-1:0];
          REG_SEQ_COUNT:  seq_count_r  <= cfg_data[SEQ_CNT_W-1:0];
          default: begin
          end
        endcase
      end

      out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          // A load after the drain has begun opens a new alignment.
          if (phase_r == PH_DRAIN) begin
            phase_r      <= PH_LOAD;
            read_index_r <= '0;
            x_r          <= '0;
            y_r          <= '0;
          end
          if (total_eff < COLS_LIM) begin
            total_r <= total_eff + CNT_W'(1);
          end else begin
            total_r <= total_eff;
          end
          if (cmd.sort_start) begin
            idx_r <= '0;
          end
        end
        OP_READ_OUT: begin
          read_index_r <= read_index_r + CNT_W'(1);
          x_r          <= x_nxt;
          y_r          <= y_nxt;
          out_valid_r  <= 1'b1;
        end
        OP_READ_EMPTY: begin
          out_valid_r <= 1'b1;
        end
        OP_SORT_CHK: begin
          if (!status.sort_more) begin
            idx_r     <= '0;
            out_ptr_r <= '0;
            pend_r    <= 1'b0;
          end
        end
        OP_SORT_CMP: begin
          if (!swap) begin
            idx_r <= idx_inc;
          end
        end
        OP_SORT_WB: begin
          if (idx_r != '0) begin
            idx_r <= idx_r - CNT_W'(1);
          end
        end
        OP_PROJ: begin
          if (status.proj_done) begin
            total_r      <= out_ptr_r;
            read_index_r <= '0;
            x_r          <= '0;
            y_r          <= '0;
            phase_r      <= PH_DRAIN;
          end else begin
            pend_r <= (idx_r < total_r);
            if (idx_r < total_r) begin
              idx_r <= idx_inc;
            end
            if (pend_r && (pcode != '0)) begin
              out_ptr_r <= out_ptr_r + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SORT_RB) begin
      a_r <= col_q;
    end
    if (cmd.op == OP_READ_OUT) begin
      out_code_r  <= rd_code;
      out_x_r     <= x_nxt;
      out_y_r     <= y_nxt;
      out_final_r <= ((read_index_r + CNT_W'(1)) == total_r);
      out_empty_r <= 1'b0;
    end else if (cmd.op == OP_READ_EMPTY) begin
      out_code_r  <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_final_r <= 1'b0;
      out_empty_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign out_x_count    = out_x_r;
  assign out_y_count    = out_y_r;
  assign out_final_step = out_final_r;
  assign out_empty_res  = out_empty_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= COLS_LIM)
    else $error("column count beyond store depth");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    read_index_r <= total_r)
    else $error("drain pointer passed the column count");

  a_compact_in_place: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PROJ) |-> (out_ptr_r <= idx_r))
    else $error("projection write pointer ahead of read pointer");

  // Empty columns are dropped, so every real result carries a nonzero code.
  a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_empty_r |-> (out_code_r != '0))
    else $error("projected result with empty code");

endmodule
